// ----- rtl/cht_pkg.sv -----
`timescale 1ns / 1ps

package cht_pkg;

  // Table geometry
  localparam int BUCKETS     = 4;
  localparam int CHAIN_DEPTH = 16;

  // Field widths of the request and result channels
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 32;
  localparam int FBKT_W = 2;
  localparam int FPOS_W = 4;
  localparam int STAT_W = 2;

  // Internal widths derived from the geometry
  localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int POS_W   = $clog2(CHAIN_DEPTH);
  localparam int LEN_W   = $clog2(CHAIN_DEPTH + 1);
  localparam int STORE_N = BUCKETS * CHAIN_DEPTH;
  localparam int ADDR_W  = $clog2(STORE_N);

  // Commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  found_key;
    logic [FBKT_W-1:0] target_bucket;
  } res_t;

  // Flat entry address of a bucket and chain position
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [BKT_W-1:0] bkt,
                                                   input logic [POS_W-1:0] pos);
    logic [31:0] flat;
    flat = 32'(bkt) * 32'(CHAIN_DEPTH) + 32'(pos);
    return ADDR_W'(flat);
  endfunction

endpackage

// ----- rtl/cht_store.sv -----
`timescale 1ns / 1ps

module cht_store (
  input  logic                        clk,
  input  cht_pkg::mem_req_t           mem_req,
  output logic [cht_pkg::KEY_W-1:0]   rdata
);
  import cht_pkg::*;

  logic [KEY_W-1:0] mem [STORE_N];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cht_hash.sv -----
`timescale 1ns / 1ps

module cht_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cht_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [cht_pkg::BKT_W-1:0] hash
);
  import cht_pkg::*;

  // Reduce the key modulo BUCKETS, DIG bits per cycle, most significant first
  localparam int DIG   = 4;
  localparam int STEPS = KEY_W / DIG;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [BKT_W:0] MODV = (BKT_W + 1)'(BUCKETS);

  logic [KEY_W-1:0] sh_r,   sh_nxt;
  logic [BKT_W-1:0] rem_r,  rem_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BKT_W-1:0] acc;
  logic [BKT_W:0]   t;

  always_comb begin
    acc = rem_r;
    t   = '0;
    for (int j = 0; j < DIG; j++) begin
      t = {acc, sh_r[KEY_W-1-j]};
      if (t >= MODV) begin
        t = t - MODV;
      end
      acc = t[BKT_W-1:0];
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = key;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = sh_r << DIG;
      rem_nxt = acc;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign hash = rem_r;

endmodule

// ----- rtl/cht_ctrl.sv -----
`timescale 1ns / 1ps

module cht_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cht_pkg::CMD_W-1:0]  in_command,
  input  logic [cht_pkg::KEY_W-1:0]  in_key,
  input  logic [cht_pkg::FBKT_W-1:0] in_bucket,
  input  logic [cht_pkg::FPOS_W-1:0] in_position,
  output logic                       hash_start,
  input  logic                       hash_done,
  input  logic [cht_pkg::BKT_W-1:0]  hash_val,
  output cht_pkg::mem_req_t          mem_req,
  input  logic [cht_pkg::KEY_W-1:0]  mem_rdata,
  output logic                       res_valid,
  output cht_pkg::res_t              res,
  input  logic                       res_take
);
  import cht_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_RDWT  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_r,  state_nxt;
  logic [CMD_W-1:0]  cmd_r,    cmd_nxt;
  logic [KEY_W-1:0]  key_r,    key_nxt;
  logic [BKT_W-1:0]  bkt_r,    bkt_nxt;
  logic              bkt_ok_r, bkt_ok_nxt;
  logic [FPOS_W-1:0] pos_r,    pos_nxt;
  logic [FBKT_W-1:0] tgt_r,    tgt_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic [POS_W-1:0]  cur_r,    cur_nxt;
  logic [STAT_W-1:0] stat_r,   stat_nxt;
  logic [KEY_W-1:0]  found_r,  found_nxt;

  logic [LEN_W-1:0]  chain_len_r [BUCKETS];
  logic              len_we;
  logic [LEN_W-1:0]  len_wdata;

  logic              accept;
  logic [LEN_W-1:0]  len_cur;
  logic              pos_past;
  logic [POS_W-1:0]  rm_pos;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign len_cur  = chain_len_r[bkt_r];
  assign pos_past = 32'(pos_r) >= 32'(len_cur);
  assign rm_pos   = pos_past ? POS_W'(len_cur - 1'b1) : POS_W'(pos_r);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    bkt_nxt    = bkt_r;
    bkt_ok_nxt = bkt_ok_r;
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    len_nxt    = len_r;
    cur_nxt    = cur_r;
    stat_nxt   = stat_r;
    found_nxt  = found_r;
    hash_start = 1'b0;
    len_we     = 1'b0;
    len_wdata  = len_cur;
    mem_req    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_command;
          key_nxt    = in_key;
          bkt_nxt    = BKT_W'(in_bucket);
          bkt_ok_nxt = 32'(in_bucket) < 32'(BUCKETS);
          pos_nxt    = in_position;
          tgt_nxt    = in_bucket;
          if (in_command == CMD_INSERT) begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bkt_nxt    = hash_val;
          bkt_ok_nxt = 1'b1;
          tgt_nxt    = FBKT_W'(hash_val);
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        found_nxt = '0;
        len_nxt   = len_cur;
        state_nxt = S_FIN;
        priority if (cmd_r == CMD_INSERT) begin
          if (32'(len_cur) >= 32'(CHAIN_DEPTH)) begin
            stat_nxt = ST_FULL;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = entry_addr(bkt_r, POS_W'(len_cur));
            mem_req.wdata = key_r;
            len_we        = 1'b1;
            len_wdata     = len_cur + 1'b1;
            stat_nxt      = ST_OK;
          end
        end else if (cmd_r == CMD_NONE || !bkt_ok_r) begin
          stat_nxt = ST_NOPOS;
        end else if (len_cur == '0) begin
          stat_nxt = ST_EMPTY;
        end else if (cmd_r == CMD_LOOKUP) begin
          if (pos_past) begin
            stat_nxt = ST_NOPOS;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = entry_addr(bkt_r, POS_W'(pos_r));
            stat_nxt      = ST_OK;
            state_nxt     = S_RDWT;
          end
        end else begin
          // Remove: clamp to the last entry, read it, shrink the chain now
          cur_nxt       = rm_pos;
          mem_req.re    = 1'b1;
          mem_req.raddr = entry_addr(bkt_r, rm_pos);
          len_we        = 1'b1;
          len_wdata     = len_cur - 1'b1;
          stat_nxt      = ST_OK;
          state_nxt     = S_RDWT;
        end
      end
      S_RDWT: begin
        found_nxt = mem_rdata;
        state_nxt = S_FIN;
        if (cmd_r == CMD_REMOVE && (32'(cur_r) + 32'd1 < 32'(len_r))) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = entry_addr(bkt_r, POS_W'(32'(cur_r) + 32'd1));
          state_nxt     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Write the entry read last cycle one place down, fetch the next one
        mem_req.we    = 1'b1;
        mem_req.waddr = entry_addr(bkt_r, cur_r);
        mem_req.wdata = mem_rdata;
        cur_nxt       = cur_r + 1'b1;
        if (32'(cur_r) + 32'd2 < 32'(len_r)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = entry_addr(bkt_r, POS_W'(32'(cur_r) + 32'd2));
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_valid         = (state_r == S_FIN);
  assign res.status        = stat_r;
  assign res.found_key     = found_r;
  assign res.target_bucket = tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int b = 0; b < BUCKETS; b++) begin
        chain_len_r[b] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (len_we) begin
        chain_len_r[bkt_r] <= len_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    bkt_r    <= bkt_nxt;
    bkt_ok_r <= bkt_ok_nxt;
    pos_r    <= pos_nxt;
    tgt_r    <= tgt_nxt;
    len_r    <= len_nxt;
    cur_r    <= cur_nxt;
    stat_r   <= stat_nxt;
    found_r  <= found_nxt;
  end

endmodule

// ----- rtl/chained_hash_table.sv -----
`timescale 1ns / 1ps

// Hash table with separate chaining over BUCKETS buckets of CHAIN_DEPTH entries.
// Request channel (in_valid / in_stall): one command per request: insert a key
// at the end of bucket key mod BUCKETS, look up the entry at bucket/position,
// or remove the entry at bucket/position and close the gap behind it.
// Result channel (out_valid / out_stall): exactly one result per request with
// status, the key read or removed, and the bucket used.
// From a request to out_valid: an insert waits in S_HASH on the modulo unit
// reducing the key four bits per cycle, then passes S_EVAL and S_FIN; a lookup
// that reads passes S_EVAL, S_RDWT and S_FIN; a remove adds one S_SHIFT step
// per entry behind the removed one, moved through the single read / single
// write entry memory. Requests are taken one at a time; in_stall is high from
// acceptance until the result is handed to the output register, so the next
// request is taken the cycle after that.
// The output register lets a finished result wait under out_stall while the
// next request is already being worked on; that request then holds in its
// final state until the register is free.
// Reset clears the chain lengths (all buckets empty) and both valid flags;
// entry memory is not cleared, since only entries below a chain's length
// are ever read.
module chained_hash_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cht_pkg::CMD_W-1:0]   in_command,
  input  logic [cht_pkg::KEY_W-1:0]   in_key,
  input  logic [cht_pkg::FBKT_W-1:0]  in_bucket,
  input  logic [cht_pkg::FPOS_W-1:0]  in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cht_pkg::STAT_W-1:0]  out_status,
  output logic [cht_pkg::KEY_W-1:0]   out_found_key,
  output logic [cht_pkg::FBKT_W-1:0]  out_target_bucket
);
  import cht_pkg::*;

  logic             hash_start;
  logic             hash_done;
  logic [BKT_W-1:0] hash_val;
  mem_req_t         mem_req;
  logic [KEY_W-1:0] mem_rdata;
  logic             res_valid;
  res_t             res;
  logic             res_take;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;

  cht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_key),
    .done  (hash_done),
    .hash  (hash_val)
  );

  cht_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  cht_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_key      (in_key),
    .in_bucket   (in_bucket),
    .in_position (in_position),
    .hash_start  (hash_start),
    .hash_done   (hash_done),
    .hash_val    (hash_val),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  // Load the output register when it is empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result while stalled; advance only on a load
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_found_key     = out_res_r.found_key;
  assign out_target_bucket = out_res_r.target_bucket;

endmodule

// ----- bench/chained_hash_table_tb.sv -----
`timescale 1ns / 1ps

module chained_hash_table_tb;
  import cht_pkg::*;

  localparam int RANDOM_ITEMS  = 1200;
  localparam int PHASE_LEN     = 150;
  localparam int SETTLE_CYCLES = 40;
  // Slowest request: idle gap after it, a remove that shifts a whole chain, and a result stall.
  // Allow roughly eight times the slowest request for every request.
  localparam int CYCLE_LIMIT   = 400000;

  // One request as the driver offers it, with the idle time that follows it.
  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key;
    logic [FBKT_W-1:0] bucket;
    logic [FPOS_W-1:0] position;
    int unsigned       gap_after;
    bit                drain_first;  // hold until every result is back
  } cmd_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = CMD_NONE;
  logic [KEY_W-1:0]  in_key = '0;
  logic [FBKT_W-1:0] in_bucket = '0;
  logic [FPOS_W-1:0] in_position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [KEY_W-1:0]  out_found_key;
  logic [FBKT_W-1:0] out_target_bucket;

  // Shadow copy of the table: chain contents and chain lengths per bucket.
  logic [KEY_W-1:0] shadow_keys [BUCKETS][CHAIN_DEPTH];
  int               shadow_len  [BUCKETS] = '{default: 0};

  cmd_item_t   cmd_backlog[$];   // requests not yet offered
  res_t        results_due[$];   // predicted results, oldest first
  cmd_item_t   tx_cur;
  int unsigned tx_gap = 0;
  bit          tx_tight = 1'b0;  // build requests with no idle cycles
  int unsigned stall_left = 0;
  int unsigned results_checked = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  res_t        rx_due;

  chained_hash_table DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_key            (in_key),
    .in_bucket         (in_bucket),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_key     (out_found_key),
    .out_target_bucket (out_target_bucket)
  );

  always #2 clk = ~clk;

  // Apply one request to the shadow table and return the result it must give.
  function automatic res_t apply_command(input cmd_item_t it);
    res_t        r;
    int unsigned b;
    int          len;
    int          p;
    r.status        = ST_OK;
    r.found_key     = '0;
    r.target_bucket = it.bucket;
    b = int'(it.bucket);
    case (it.command)
      CMD_INSERT: begin
        // Hash is the key modulo the bucket count; append at the chain end.
        b = int'(it.key % 32'(BUCKETS));
        r.target_bucket = FBKT_W'(b);
        if (shadow_len[b] >= CHAIN_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[b][shadow_len[b]] = it.key;
          shadow_len[b]++;
        end
      end
      CMD_LOOKUP: begin
        if (b >= BUCKETS) begin
          r.status = ST_NOPOS;
        end else begin
          len = shadow_len[b];
          if (len == 0)
            r.status = ST_EMPTY;
          else if (int'(it.position) >= len)
            r.status = ST_NOPOS;
          else
            r.found_key = shadow_keys[b][it.position];
        end
      end
      CMD_REMOVE: begin
        if (b >= BUCKETS) begin
          r.status = ST_NOPOS;
        end else begin
          len = shadow_len[b];
          if (len == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // A position past the chain end takes the last entry.
            p = (int'(it.position) >= len) ? len - 1 : int'(it.position);
            r.found_key = shadow_keys[b][p];
            for (int i = p; i + 1 < len; i++)
              shadow_keys[b][i] = shadow_keys[b][i + 1];
            shadow_len[b] = len - 1;
          end
        end
      end
      default: begin
        // Unknown command: no change, reported as no such position.
        r.status = ST_NOPOS;
      end
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic [FBKT_W-1:0] b, input logic [FPOS_W-1:0] p,
                           input bit drain);
    cmd_item_t it;
    it.command     = c;
    it.key         = k;
    it.bucket      = b;
    it.position    = p;
    it.gap_after   = tx_tight ? 0 : $urandom_range(0, 9);
    it.drain_first = drain;
    cmd_backlog.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [KEY_W-1:0] exp_val,
                             input logic [KEY_W-1:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Request driver: predict each accepted request, then hold, idle or advance.
  // The payload only changes when a new request is popped, so it stays put
  // for as long as in_stall holds it off.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        results_due.push_back(apply_command(tx_cur));
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          // Idle after the last request.
          tx_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain_first && results_due.size() != 0)) begin
          tx_cur = cmd_backlog.pop_front();
          tx_gap = tx_cur.gap_after;
          in_command  <= tx_cur.command;
          in_key      <= tx_cur.key;
          in_bucket   <= tx_cur.bucket;
          in_position <= tx_cur.position;
          in_valid    <= 1'b1;
        end else begin
          // Nothing to send, or hold off until the block has drained.
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction,
  // then stall for a random number of cycles. Every fourth stretch of 80
  // results runs with no stall at all.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got status %0d key %0h bucket %0d",
                   $time, out_status, out_found_key, out_target_bucket);
        end else begin
          rx_due = results_due.pop_front();
          check_field("status", KEY_W'(rx_due.status), KEY_W'(out_status));
          check_field("found_key", rx_due.found_key, out_found_key);
          check_field("target_bucket", KEY_W'(rx_due.target_bucket),
                      KEY_W'(out_target_bucket));
        end
        results_checked++;
        stall_left = (((results_checked / 80) % 4) == 2) ? 0 : $urandom_range(0, 9);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0]  k;
    logic [FBKT_W-1:0] b;
    logic [FBKT_W-1:0] hot;
    logic [FPOS_W-1:0] p;
    logic [CMD_W-1:0]  c;
    int unsigned       roll;
    bit                fill_phase;

    // Directed part: empty table, unknown command, key extremes, one chain
    // filled to the brim, removal of the last entry and from the head.
    hot = '0;
    queue_cmd(CMD_LOOKUP, '0, 2'd0, 4'd0, 1'b0);              // lookup, empty bucket
    queue_cmd(CMD_REMOVE, '0, 2'd3, 4'd15, 1'b0);             // remove, empty bucket
    queue_cmd(CMD_NONE, 32'hFFFF_FFFF, 2'd3, 4'd15, 1'b0);    // unknown command
    queue_cmd(CMD_INSERT, 32'h0000_0000, 2'd1, 4'd5, 1'b0);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 2'd0, 4'd0, 1'b0);
    queue_cmd(CMD_LOOKUP, '0, 2'd3, 4'd0, 1'b0);
    queue_cmd(CMD_LOOKUP, '0, 2'd3, 4'd15, 1'b0);             // lookup past chain end
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFE, 2'd0, 4'd0, 1'b0);
    for (int i = 1; i < CHAIN_DEPTH; i++) begin
      k = $urandom();
      k[FBKT_W-1:0] = 2'd2;
      queue_cmd(CMD_INSERT, k, 2'd0, 4'd0, 1'b0);
    end
    queue_cmd(CMD_INSERT, 32'h0000_0006, 2'd0, 4'd0, 1'b0);  // bucket full
    queue_cmd(CMD_REMOVE, '0, 2'd2, 4'd15, 1'b0);             // last position: last entry
    queue_cmd(CMD_REMOVE, '0, 2'd2, 4'd0, 1'b0);              // head: shift the rest
    queue_cmd(CMD_LOOKUP, '0, 2'd0, 4'd0, 1'b0);

    // Random part: alternate phases that fill the table and drain it, so
    // chains reach full and empty again. Every fourth phase sends back to back.
    // Twice the driver waits for the block to drain before going on.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      fill_phase = ((n / PHASE_LEN) % 2) == 0;
      tx_tight   = ((n / PHASE_LEN) % 4) == 3;
      if (n % PHASE_LEN == 0)
        hot = FBKT_W'($urandom_range(0, BUCKETS - 1));
      roll = $urandom_range(0, 99);
      k = $urandom();
      if ($urandom_range(0, 2) == 0)
        k[FBKT_W-1:0] = hot;   // pile keys onto one bucket
      b = FBKT_W'($urandom_range(0, 3));
      p = ($urandom_range(0, 1) != 0) ? FPOS_W'($urandom_range(0, 15))
                                      : FPOS_W'($urandom_range(0, 3));
      if (roll < 5)
        c = CMD_NONE;
      else if (roll < (fill_phase ? 65 : 20))
        c = CMD_INSERT;
      else if (roll < (fill_phase ? 88 : 45))
        c = CMD_LOOKUP;
      else
        c = CMD_REMOVE;
      queue_cmd(c, k, b, p, (n == 400 || n == 900));
    end
    tx_tight = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go out and every result to come back,
    // then let the block settle in case a stray result follows.
    while (cmd_backlog.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cht_pkg.sv
rtl/cht_store.sv
rtl/cht_hash.sv
rtl/cht_ctrl.sv
rtl/chained_hash_table.sv
bench/chained_hash_table_tb.sv
